// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent checks clocked on clk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that is switched off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also holds while reset is asserted.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/bslm_pkg.sv =====
// ----------------------------------------------------------------------------
// bslm_pkg
// Types and constants shared by the spin length mean unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bslm_pkg;

  localparam logic [2:0] OP_SAMPLE    = 3'd0;
  localparam logic [2:0] OP_COMMIT    = 3'd1;
  localparam logic [2:0] OP_COUNT     = 3'd2;
  localparam logic [2:0] OP_RESET_AVG = 3'd3;
  localparam logic [2:0] OP_READ      = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam int SWEEP_SUM_W = 36;
  localparam int MEAN_SUM_W  = 60;
  localparam int REPORT_W    = 7;
  localparam logic [REPORT_W-1:0] REPORT_RESET = 7'd63;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] ax;
    logic [15:0] ay;
    logic [15:0] az;
    logic [5:0]  bin;
    logic        in_bins;
  } bslm_item_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } bslm_ctl_t;

endpackage

`default_nettype wire

// ===== sv/bslm_front.sv =====
// ----------------------------------------------------------------------------
// bslm_front
// Accepts command words, decodes them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bslm_front
  import bslm_pkg::*;
#(
  parameter int BINS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_operation,
  input  wire logic [15:0] in_spin_x,
  input  wire logic [15:0] in_spin_y,
  input  wire logic [15:0] in_spin_z,
  input  wire logic [5:0]  in_bin_id,
  input  wire bslm_ctl_t   ctl,
  output bslm_item_t       head,
  output logic             head_valid
);

  bslm_item_t q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wr_r, wr_nxt;
  logic       rd_r, rd_nxt;
  logic       accept;
  bslm_item_t item;

  function automatic logic [15:0] abs16(input logic [15:0] v);
    abs16 = v[15] ? 16'(~v + 16'd1) : v;
  endfunction

  always_comb begin
    item.op      = in_operation;
    item.ax      = abs16(in_spin_x);
    item.ay      = abs16(in_spin_y);
    item.az      = abs16(in_spin_z);
    item.bin     = in_bin_id;
    item.in_bins = 32'(in_bin_id) < BINS;
  end

  assign busy       = (cnt_r == 2'd2) || ctl.clearing;
  assign accept     = start && !busy;
  assign head       = q_r[rd_r];
  assign head_valid = cnt_r != 2'd0;

  always_comb begin
    wr_nxt  = accept ? !wr_r : wr_r;
    rd_nxt  = ctl.pop ? !rd_r : rd_r;
    cnt_nxt = cnt_r + 2'(accept) - 2'(ctl.pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_r[wr_r] <= item;
    end
  end

  `ASSERT_ALWAYS(a_fifo_bound, !rst_n || cnt_r != 2'd3, "Queue count beyond its depth.")
  `ASSERT_CLK(a_pop_nonempty, ctl.pop |-> cnt_r != 2'd0, "Word taken from an empty queue.")

endmodule

`default_nettype wire

// ===== sv/bslm_back.sv =====
// ----------------------------------------------------------------------------
// bslm_back
// Executes decoded words against the per-bin stores and produces results.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bslm_back
  import bslm_pkg::*;
#(
  parameter int BINS             = 64,
  parameter int ATOM_COUNT_BITS  = 20,
  parameter int SWEEP_COUNT_BITS = 24
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_write_en,
  input  wire logic [REPORT_W-1:0] cfg_reported_bins,
  input  wire bslm_item_t          head,
  input  wire logic                head_valid,
  output bslm_ctl_t                ctl,
  output logic                     out_strobe,
  output logic [15:0]              out_mean_length,
  output logic [1:0]               out_status
);

  localparam int AW  = (BINS > 1) ? $clog2(BINS) : 1;
  localparam int ACB = ATOM_COUNT_BITS;
  localparam int SCB = SWEEP_COUNT_BITS;
  localparam int DW  = SCB + ACB + 16;
  localparam int CW  = (DW > MEAN_SUM_W) ? DW : MEAN_SUM_W;

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_SQ     = 4'd2;
  localparam logic [3:0] S_ROOT   = 4'd3;
  localparam logic [3:0] S_CNT_RD = 4'd4;
  localparam logic [3:0] S_CNT_WR = 4'd5;
  localparam logic [3:0] S_CMT_RD = 4'd6;
  localparam logic [3:0] S_CMT_WR = 4'd7;
  localparam logic [3:0] S_RST    = 4'd8;
  localparam logic [3:0] S_RD_RD  = 4'd9;
  localparam logic [3:0] S_RD_MUL = 4'd10;
  localparam logic [3:0] S_DIV    = 4'd11;

  logic [SWEEP_SUM_W-1:0] sweep_mem [BINS];
  logic [MEAN_SUM_W-1:0]  mean_mem  [BINS];
  logic [ACB-1:0]         atom_mem  [BINS];
  logic [SWEEP_SUM_W-1:0] sweep_rd_r;
  logic [MEAN_SUM_W-1:0]  mean_rd_r;
  logic [ACB-1:0]         atom_rd_r;

  logic                   sw_we, mn_we, at_we;
  logic [SWEEP_SUM_W-1:0] sw_wd;
  logic [MEAN_SUM_W-1:0]  mn_wd;
  logic [ACB-1:0]         at_wd;

  logic [3:0]          state_r, state_nxt;
  logic [AW-1:0]       addr_r, addr_nxt;
  bslm_item_t          item_r, item_nxt;
  logic [REPORT_W-1:0] report_r, report_nxt;
  logic [SCB-1:0]      sweeps_r, sweeps_nxt;
  logic [1:0]          sq_cnt_r, sq_cnt_nxt;
  logic [31:0]         acc_r, acc_nxt;
  logic [31:0]         val_r, val_nxt;
  logic [31:0]         root_r, root_nxt;
  logic [31:0]         bit_r, bit_nxt;
  logic [MEAN_SUM_W-1:0] rem_r, rem_nxt;
  logic [DW-1:0]       ds_r, ds_nxt;
  logic [15:0]         quo_r, quo_nxt;
  logic [4:0]          dc_r, dc_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [15:0]         out_mean_r, out_mean_nxt;
  logic [1:0]          out_status_r, out_status_nxt;

  logic [15:0]            sq_sel;
  logic [31:0]            sq;
  logic [31:0]            trial;
  logic [SWEEP_SUM_W:0]   sw_sum;
  logic [MEAN_SUM_W:0]    mn_sum;
  logic [CW-1:0]          rem_ext, ds_ext;
  logic                   ge;
  logic                   last;

  always_comb begin
    case (sq_cnt_r)
      2'd0:    sq_sel = item_r.ax;
      2'd1:    sq_sel = item_r.ay;
      default: sq_sel = item_r.az;
    endcase
    sq      = 32'(sq_sel) * 32'(sq_sel);
    trial   = root_r + bit_r;
    sw_sum  = {1'b0, sweep_rd_r} + (SWEEP_SUM_W + 1)'(root_r[15:0]);
    mn_sum  = {1'b0, mean_rd_r} + (MEAN_SUM_W + 1)'(sweep_rd_r);
    rem_ext = CW'(rem_r);
    ds_ext  = CW'(ds_r);
    ge      = rem_ext >= ds_ext;
    last    = addr_r == AW'(BINS - 1);
  end

  always_comb begin
    state_nxt      = state_r;
    addr_nxt       = addr_r;
    item_nxt       = item_r;
    report_nxt     = cfg_write_en ? cfg_reported_bins : report_r;
    sweeps_nxt     = sweeps_r;
    sq_cnt_nxt     = sq_cnt_r;
    acc_nxt        = acc_r;
    val_nxt        = val_r;
    root_nxt       = root_r;
    bit_nxt        = bit_r;
    rem_nxt        = rem_r;
    ds_nxt         = ds_r;
    quo_nxt        = quo_r;
    dc_nxt         = dc_r;
    out_valid_nxt  = 1'b0;
    out_mean_nxt   = 16'd0;
    out_status_nxt = ST_OK;
    sw_we          = 1'b0;
    mn_we          = 1'b0;
    at_we          = 1'b0;
    sw_wd          = '0;
    mn_wd          = '0;
    at_wd          = '0;
    ctl.pop        = 1'b0;
    ctl.clearing   = state_r == S_CLR;

    case (state_r)
      S_CLR: begin
        sw_we    = 1'b1;
        mn_we    = 1'b1;
        at_we    = 1'b1;
        addr_nxt = last ? '0 : addr_r + AW'(1);
        if (last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (head_valid) begin
          ctl.pop  = 1'b1;
          item_nxt = head;
          addr_nxt = AW'(head.bin);
          case (head.op)
            OP_SAMPLE: begin
              if (head.in_bins) begin
                acc_nxt    = '0;
                sq_cnt_nxt = 2'd0;
                state_nxt  = S_SQ;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            OP_COMMIT: begin
              addr_nxt  = '0;
              state_nxt = S_CMT_RD;
            end
            OP_COUNT: begin
              if (head.in_bins) begin
                state_nxt = S_CNT_RD;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            OP_RESET_AVG: begin
              sweeps_nxt = '0;
              addr_nxt   = '0;
              state_nxt  = S_RST;
            end
            OP_READ: begin
              if (!head.in_bins || 7'(head.bin) >= report_r) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_RANGE;
              end else if (sweeps_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_RD_RD;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_SQ: begin
        acc_nxt    = acc_r + sq;
        sq_cnt_nxt = sq_cnt_r + 2'd1;
        if (sq_cnt_r == 2'd2) begin
          val_nxt   = acc_r + sq;
          root_nxt  = '0;
          bit_nxt   = 32'd1 << 30;
          state_nxt = S_ROOT;
        end
      end
      S_ROOT: begin
        if (bit_r == '0) begin
          sw_we         = 1'b1;
          sw_wd         = sw_sum[SWEEP_SUM_W] ? '1 : sw_sum[SWEEP_SUM_W-1:0];
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          if (val_r >= trial) begin
            val_nxt  = val_r - trial;
            root_nxt = (root_r >> 1) + bit_r;
          end else begin
            root_nxt = root_r >> 1;
          end
          bit_nxt = bit_r >> 2;
        end
      end
      S_CNT_RD: begin
        state_nxt = S_CNT_WR;
      end
      S_CNT_WR: begin
        at_we         = 1'b1;
        at_wd         = (atom_rd_r == '1) ? atom_rd_r : atom_rd_r + ACB'(1);
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_CMT_RD: begin
        state_nxt = S_CMT_WR;
      end
      S_CMT_WR: begin
        sw_we = 1'b1;
        if (atom_rd_r != '0) begin
          mn_we = 1'b1;
          mn_wd = mn_sum[MEAN_SUM_W] ? '1 : mn_sum[MEAN_SUM_W-1:0];
        end
        if (last) begin
          if (sweeps_r != '1) begin
            sweeps_nxt = sweeps_r + SCB'(1);
          end
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          addr_nxt  = addr_r + AW'(1);
          state_nxt = S_CMT_RD;
        end
      end
      S_RST: begin
        mn_we = 1'b1;
        if (last) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          addr_nxt = addr_r + AW'(1);
        end
      end
      S_RD_RD: begin
        state_nxt = S_RD_MUL;
      end
      S_RD_MUL: begin
        if (atom_rd_r == '0) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_EMPTY;
          state_nxt      = S_IDLE;
        end else begin
          ds_nxt    = DW'(DW'(sweeps_r) * DW'(atom_rd_r)) << 16;
          rem_nxt   = mean_rd_r;
          quo_nxt   = '0;
          dc_nxt    = 5'd16;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (dc_r == 5'd16 && ge) begin
          out_valid_nxt = 1'b1;
          out_mean_nxt  = 16'hFFFF;
          state_nxt     = S_IDLE;
        end else begin
          if (ge) begin
            rem_nxt = MEAN_SUM_W'(rem_ext - ds_ext);
          end
          quo_nxt = {quo_r[14:0], ge};
          ds_nxt  = ds_r >> 1;
          dc_nxt  = dc_r - 5'd1;
          if (dc_r == 5'd0) begin
            out_valid_nxt = 1'b1;
            out_mean_nxt  = {quo_r[14:0], ge};
            state_nxt     = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      addr_r      <= '0;
      report_r    <= REPORT_RESET;
      sweeps_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      report_r    <= report_nxt;
      sweeps_r    <= sweeps_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r       <= item_nxt;
    sq_cnt_r     <= sq_cnt_nxt;
    acc_r        <= acc_nxt;
    val_r        <= val_nxt;
    root_r       <= root_nxt;
    bit_r        <= bit_nxt;
    rem_r        <= rem_nxt;
    ds_r         <= ds_nxt;
    quo_r        <= quo_nxt;
    dc_r         <= dc_nxt;
    out_mean_r   <= out_mean_nxt;
    out_status_r <= out_status_nxt;
  end

  always_ff @(posedge clk) begin
    if (sw_we) begin
      sweep_mem[addr_r] <= sw_wd;
    end
    sweep_rd_r <= sweep_mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (mn_we) begin
      mean_mem[addr_r] <= mn_wd;
    end
    mean_rd_r <= mean_mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (at_we) begin
      atom_mem[addr_r] <= at_wd;
    end
    atom_rd_r <= atom_mem[addr_r];
  end

  assign out_strobe      = out_valid_r;
  assign out_mean_length = out_mean_r;
  assign out_status      = out_status_r;

  `ASSERT_CLK(a_clr_silent, (state_r == S_CLR) |=> !out_valid_r, "Result issued during clearing.")
  `ASSERT_CLK(a_root_done, (state_r == S_ROOT && bit_r == '0) |=> out_valid_r, "Sample gave no result.")
  `ASSERT_CLK(a_pop_idle, ctl.pop |-> (state_r == S_IDLE && head_valid), "Word taken while executing.")

endmodule

`default_nettype wire

// ===== sv/binned_spin_length_mean_unit.sv =====
// ----------------------------------------------------------------------------
// binned_spin_length_mean_unit
// Per-bin sums of spin magnitudes with committed sweep means and mean reads.
// ----------------------------------------------------------------------------
// One word is executed at a time behind a two-word queue that takes start
// while it runs; the 16-step square root serves samples, the 17-step
// divider serves reads, and commit and reset averages sweep every bin.
// After reset a clearing pass over every bin holds busy high; results are
// strobed for one cycle and the receiver cannot stall.
`default_nettype none

module binned_spin_length_mean_unit
  import bslm_pkg::*;
#(
  parameter int BINS             = 64,
  parameter int ATOM_COUNT_BITS  = 20,
  parameter int SWEEP_COUNT_BITS = 24
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [2:0]          in_operation,
  input  wire logic [15:0]         in_spin_x,
  input  wire logic [15:0]         in_spin_y,
  input  wire logic [15:0]         in_spin_z,
  input  wire logic [5:0]          in_bin_id,
  input  wire logic                cfg_write_en,
  input  wire logic [REPORT_W-1:0] cfg_reported_bins,
  output logic                     out_strobe,
  output logic [15:0]              out_mean_length,
  output logic [1:0]               out_status
);

  bslm_item_t head;
  logic       head_valid;
  bslm_ctl_t  ctl;

  bslm_front #(
    .BINS(BINS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_operation(in_operation),
    .in_spin_x   (in_spin_x),
    .in_spin_y   (in_spin_y),
    .in_spin_z   (in_spin_z),
    .in_bin_id   (in_bin_id),
    .ctl         (ctl),
    .head        (head),
    .head_valid  (head_valid)
  );

  bslm_back #(
    .BINS            (BINS),
    .ATOM_COUNT_BITS (ATOM_COUNT_BITS),
    .SWEEP_COUNT_BITS(SWEEP_COUNT_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_write_en     (cfg_write_en),
    .cfg_reported_bins(cfg_reported_bins),
    .head             (head),
    .head_valid       (head_valid),
    .ctl              (ctl),
    .out_strobe       (out_strobe),
    .out_mean_length  (out_mean_length),
    .out_status       (out_status)
  );

endmodule

`default_nettype wire
